@@ rtl/core/wsfp_pkg.sv @@
// Package for the wind sentence field parser.
// Constants, register map and saturation helpers; no dependencies.
`default_nettype none
package wsfp_pkg;

  localparam int unsigned MAX_PACKET_BYTES_DEF = 64;

  localparam int unsigned VAL_W   = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 32;

  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h24;
  localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'h0A;

  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CHAR_POINT = 8'h2E;
  localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;

  // register select, taken from paddr[2]
  localparam logic REG_START_BYTE = 1'b0;
  localparam logic REG_END_BYTE   = 1'b1;

  // token numbering; TOK_PAST means beyond the speed token
  localparam logic [1:0] TOK_HEAD  = 2'd0;
  localparam logic [1:0] TOK_DIR   = 2'd1;
  localparam logic [1:0] TOK_SPEED = 2'd2;
  localparam logic [1:0] TOK_PAST  = 2'd3;

  localparam logic [1:0] FRAC_NONE = 2'd0;
  localparam logic [1:0] FRAC_ONE  = 2'd1;
  localparam logic [1:0] FRAC_DONE = 2'd2;

  localparam logic [VAL_W-1:0] SAT_MAX = {VAL_W{1'b1}};

  function automatic logic [VAL_W-1:0] sat16(input logic [22:0] v);
    sat16 = (v > 23'(SAT_MAX)) ? SAT_MAX : v[VAL_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/wind_sentence_field_parser.sv @@
// Wind sentence field parser, top level.
// Depends on wsfp_pkg.
//
// Usage: one received byte per in_ beat on in_tdata[7:0]. The start byte
// opens a packet; body bytes are split at commas or NUL (empty tokens skipped).
// Token 1 gives the direction, token 2 the speed in 0.01 m/s, both
// saturating at 65535. The end byte commits the packet's values and sends
// one out_ beat with the stored direction and speed.
// Timing: every byte is handled in the cycle it is accepted; a result
// appears on out_ the cycle after its end byte, and one byte is taken
// every cycle while the result register is free or being drained.
// in_tready drops only while a result waits and out_tready is low.
// Reset (rst_n low, synchronous) clears the parser state and the stored
// values and restores start_byte to '$' and end_byte to LF.
// Configuration: APB port, start_byte at 0x0, end_byte at 0x4.
`default_nettype none
module wind_sentence_field_parser #(
  parameter int unsigned MAX_PACKET_BYTES = wsfp_pkg::MAX_PACKET_BYTES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,    // [7:0] rx_byte
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [31:0]                      out_tdata,   // [15:0] direction, [31:16] speed
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [wsfp_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [wsfp_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [wsfp_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                             cfg_pready
);

  localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES);
  localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(MAX_PACKET_BYTES - 1);
  localparam int unsigned VW = wsfp_pkg::VAL_W;

  logic [7:0]    start_byte_r, end_byte_r;
  logic          in_packet_r, in_packet_nxt;
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [1:0]    token_index_r, token_index_nxt;
  logic          token_nonempty_r, token_nonempty_nxt;
  logic          seen_point_r, seen_point_nxt;
  logic [1:0]    fraction_digits_r, fraction_digits_nxt;
  logic [VW-1:0] acc_r, acc_nxt;
  logic [VW-1:0] stored_dir_r, stored_dir_nxt;
  logic [VW-1:0] stored_spd_r, stored_spd_nxt;
  logic [VW-1:0] pend_dir_r, pend_dir_nxt;
  logic [VW-1:0] pend_spd_r, pend_spd_nxt;
  logic          pend_dir_v_r, pend_dir_v_nxt;
  logic          pend_spd_v_r, pend_spd_v_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          in_fire, cfg_wr;
  logic [7:0]    rx;
  logic          is_start, is_end, is_digit;
  logic [3:0]    dval;

  // token completion seen from the current state
  logic [VW-1:0] fin_dir, fin_spd;
  logic          fin_dir_v, fin_spd_v;
  logic [1:0]    fin_tok;

  logic [VW-1:0] mac10, mul100, fracadd;

  assign in_fire    = in_tvalid & in_tready;
  assign in_tready  = ~out_valid_r | out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {stored_spd_r, stored_dir_r};
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    unique case (cfg_paddr[2])
      wsfp_pkg::REG_START_BYTE: cfg_prdata = {24'd0, start_byte_r};
      wsfp_pkg::REG_END_BYTE:   cfg_prdata = {24'd0, end_byte_r};
      default:                  cfg_prdata = '0;
    endcase
  end

  assign rx       = in_tdata;
  assign is_start = (rx == start_byte_r);
  assign is_end   = (rx == end_byte_r);
  assign is_digit = (rx >= wsfp_pkg::CHAR_0) && (rx <= wsfp_pkg::CHAR_9);
  assign dval     = is_digit ? 4'(rx - wsfp_pkg::CHAR_0) : 4'd0;

  assign mac10   = wsfp_pkg::sat16(23'(acc_r) * 23'd10 + 23'(dval));
  assign mul100  = wsfp_pkg::sat16(23'(acc_r) * 23'd100);
  assign fracadd = wsfp_pkg::sat16(23'(acc_r) +
                   ((fraction_digits_r == wsfp_pkg::FRAC_NONE) ?
                    23'(dval) * 23'd10 : 23'(dval)));

  always_comb begin
    fin_dir   = pend_dir_r;
    fin_dir_v = pend_dir_v_r;
    fin_spd   = pend_spd_r;
    fin_spd_v = pend_spd_v_r;
    fin_tok   = token_index_r;
    if (token_nonempty_r) begin
      if (token_index_r == wsfp_pkg::TOK_DIR) begin
        fin_dir   = acc_r;
        fin_dir_v = 1'b1;
      end else if (token_index_r == wsfp_pkg::TOK_SPEED) begin
        fin_spd   = seen_point_r ? acc_r : mul100;
        fin_spd_v = 1'b1;
      end
      if (token_index_r != wsfp_pkg::TOK_PAST) fin_tok = token_index_r + 2'd1;
    end
  end

  always_comb begin
    in_packet_nxt       = in_packet_r;
    byte_count_nxt      = byte_count_r;
    token_index_nxt     = token_index_r;
    token_nonempty_nxt  = token_nonempty_r;
    seen_point_nxt      = seen_point_r;
    fraction_digits_nxt = fraction_digits_r;
    acc_nxt             = acc_r;
    stored_dir_nxt      = stored_dir_r;
    stored_spd_nxt      = stored_spd_r;
    pend_dir_nxt        = pend_dir_r;
    pend_spd_nxt        = pend_spd_r;
    pend_dir_v_nxt      = pend_dir_v_r;
    pend_spd_v_nxt      = pend_spd_v_r;
    out_valid_nxt       = out_valid_r & ~out_tready;

    if (in_fire) begin
      if (is_start || is_end) begin
        in_packet_nxt       = is_start;
        byte_count_nxt      = '0;
        token_index_nxt     = wsfp_pkg::TOK_HEAD;
        token_nonempty_nxt  = 1'b0;
        seen_point_nxt      = 1'b0;
        fraction_digits_nxt = wsfp_pkg::FRAC_NONE;
        acc_nxt             = '0;
        pend_dir_v_nxt      = 1'b0;
        pend_spd_v_nxt      = 1'b0;
        if (!is_start) begin
          if (fin_dir_v) stored_dir_nxt = fin_dir;
          if (fin_spd_v) stored_spd_nxt = fin_spd;
          out_valid_nxt = 1'b1;
        end
      end else if (in_packet_r && byte_count_r < CNT_LIM) begin
        byte_count_nxt = byte_count_r + 1'b1;
        if (rx == wsfp_pkg::CHAR_NUL || rx == wsfp_pkg::CHAR_COMMA) begin
          token_index_nxt     = fin_tok;
          pend_dir_nxt        = fin_dir;
          pend_dir_v_nxt      = fin_dir_v;
          pend_spd_nxt        = fin_spd;
          pend_spd_v_nxt      = fin_spd_v;
          token_nonempty_nxt  = 1'b0;
          seen_point_nxt      = 1'b0;
          fraction_digits_nxt = wsfp_pkg::FRAC_NONE;
          acc_nxt             = '0;
          if (rx == wsfp_pkg::CHAR_NUL) byte_count_nxt = CNT_LIM;
        end else begin
          token_nonempty_nxt = 1'b1;
          if (token_index_r == wsfp_pkg::TOK_DIR) begin
            if (!seen_point_r) begin
              if (is_digit) acc_nxt = mac10;
              else seen_point_nxt = 1'b1;
            end
          end else if (token_index_r == wsfp_pkg::TOK_SPEED) begin
            if (!seen_point_r) begin
              if (is_digit) begin
                acc_nxt = mac10;
              end else begin
                acc_nxt             = mul100;
                seen_point_nxt      = 1'b1;
                fraction_digits_nxt = (rx == wsfp_pkg::CHAR_POINT) ?
                                      wsfp_pkg::FRAC_NONE : wsfp_pkg::FRAC_DONE;
              end
            end else if (fraction_digits_r != wsfp_pkg::FRAC_DONE && is_digit) begin
              acc_nxt             = fracadd;
              fraction_digits_nxt = fraction_digits_r + 2'd1;
            end else begin
              fraction_digits_nxt = wsfp_pkg::FRAC_DONE;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r      <= wsfp_pkg::START_BYTE_RST;
      end_byte_r        <= wsfp_pkg::END_BYTE_RST;
      in_packet_r       <= 1'b0;
      byte_count_r      <= '0;
      token_index_r     <= wsfp_pkg::TOK_HEAD;
      token_nonempty_r  <= 1'b0;
      seen_point_r      <= 1'b0;
      fraction_digits_r <= wsfp_pkg::FRAC_NONE;
      acc_r             <= '0;
      stored_dir_r      <= '0;
      stored_spd_r      <= '0;
      pend_dir_v_r      <= 1'b0;
      pend_spd_v_r      <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_paddr[2])
          wsfp_pkg::REG_START_BYTE: start_byte_r <= cfg_pwdata[7:0];
          wsfp_pkg::REG_END_BYTE:   end_byte_r   <= cfg_pwdata[7:0];
          default: ;
        endcase
      end
      in_packet_r       <= in_packet_nxt;
      byte_count_r      <= byte_count_nxt;
      token_index_r     <= token_index_nxt;
      token_nonempty_r  <= token_nonempty_nxt;
      seen_point_r      <= seen_point_nxt;
      fraction_digits_r <= fraction_digits_nxt;
      acc_r             <= acc_nxt;
      stored_dir_r      <= stored_dir_nxt;
      stored_spd_r      <= stored_spd_nxt;
      pend_dir_v_r      <= pend_dir_v_nxt;
      pend_spd_v_r      <= pend_spd_v_nxt;
      out_valid_r       <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_dir_r <= pend_dir_nxt;
    pend_spd_r <= pend_spd_nxt;
  end

  a_frac_needs_point: assert property (@(posedge clk) disable iff (!rst_n)
    fraction_digits_r != wsfp_pkg::FRAC_NONE |-> seen_point_r)
    else $error("fraction digits counted without a point");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= CNT_LIM)
    else $error("byte count past buffer limit");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !in_packet_r |-> (byte_count_r == '0 && !token_nonempty_r &&
                      token_index_r == wsfp_pkg::TOK_HEAD &&
                      !pend_dir_v_r && !pend_spd_v_r))
    else $error("parse state left outside a packet");

  a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_end && !is_start |=> out_valid_r)
    else $error("end byte without result");

  a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_start && !out_valid_r |=> !out_valid_r && in_packet_r)
    else $error("start byte produced a result");

endmodule
`default_nettype wire
